FILE: hdl/sft_pkg.sv
// ----------------------------------------------------------------------------
// sft_pkg
// Shared constants, codes and record types of the submission/fence tracker.
// ----------------------------------------------------------------------------
package sft_pkg;

	localparam int MAX_SUB_DEF   = 64;
	localparam int MAX_FENCE_DEF = 32;

	localparam int OP_W      = 3;
	localparam int QUEUE_W   = 16;
	localparam int ADDR_W    = 64;
	localparam int EXT_W     = 32;
	localparam int TOKEN_W   = 8;   // token on the input side
	localparam int TOKEN_O_W = 7;   // token on the result side
	localparam int PHASE_W   = 3;

	localparam logic [OP_W-1:0] OP_SUBMIT   = 3'd0;
	localparam logic [OP_W-1:0] OP_COMPLETE = 3'd1;
	localparam logic [OP_W-1:0] OP_SYNC     = 3'd2;
	localparam logic [OP_W-1:0] OP_REACQ    = 3'd3;
	localparam logic [OP_W-1:0] OP_QUERY    = 3'd4;

	localparam logic [PHASE_W-1:0] PH_SUBMITTED  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_COMPLETED  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_SYNCED     = 3'd3;
	localparam logic [PHASE_W-1:0] PH_REACQUIRED = 3'd4;

	typedef enum logic [3:0] {
		ST_OK             = 4'd0,
		ST_BAD_ARG        = 4'd1,
		ST_FULL           = 4'd2,
		ST_UNKNOWN_SUB    = 4'd3,
		ST_QUEUE_MISMATCH = 4'd4,
		ST_BAD_STATE      = 4'd5,
		ST_DUPLICATE      = 4'd6,
		ST_UNKNOWN_FENCE  = 4'd7,
		ST_NOT_IN_FENCE   = 4'd8
	} status_t;

	// one slot record as held in the slot memory
	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [QUEUE_W-1:0] queue;
		logic [ADDR_W-1:0]  addr;
		logic [EXT_W-1:0]   ext;
	} slot_t;

	typedef struct packed {
		logic               flag;
		logic [EXT_W-1:0]   ext;
		logic [ADDR_W-1:0]  addr;
		logic [TOKEN_O_W-1:0] token;
		status_t            status;
	} result_t;

	localparam int SLOT_W = $bits(slot_t);

endpackage

FILE: hdl/sft_ram.sv
// ----------------------------------------------------------------------------
// sft_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sft_ram #(
	parameter int DW = sft_pkg::SLOT_W,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/submission_fence_tracker.sv
// ----------------------------------------------------------------------------
// submission_fence_tracker
// Buffer submission table and fence table with sync-set validation.
// ----------------------------------------------------------------------------
//
// channel | dir | signals                    | content
// --------+-----+----------------------------+--------------------------------
// s_*     | in  | s_tvalid s_tready s_tdata  | command; s_tlast = last_elem
// m_*     | out | m_tvalid m_tready m_tdata  | result, zero or one per command
//
// One command at a time. Submit, query and argument errors are answered
// from S_EXEC, complete from S_CPL. A sync set of n tokens: non-last
// elements are only gathered; the last one runs a member/slot read-evaluate
// loop over the n tokens to validate, the same again to commit. Reacquire
// over a fence of n members walks the member memory -> slot memory read
// chain. Reset clears counters and control state only; no memory clearing
// pass. The next command is taken once the result has been transferred.
module submission_fence_tracker #(
	parameter int MAX_SUB   = sft_pkg::MAX_SUB_DEF,
	parameter int MAX_FENCE = sft_pkg::MAX_FENCE_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// operation, queue_id, buf_address, buf_extent, sub_token, fence_id, pad
	input  logic [135:0] s_tdata,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status, token_out, address_out, extent_out, consumed_flag, pad
	output logic [111:0] m_tdata
);
	import sft_pkg::*;

	localparam int SW  = $clog2(MAX_SUB);
	localparam int CW  = $clog2(MAX_SUB + 1);
	localparam int FW  = $clog2(MAX_FENCE);
	localparam int FCW = $clog2(MAX_FENCE + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_CPL,
		S_CHK_MEM, S_CHK_SLOT, S_CHK_EVAL,
		S_COM_MEM, S_COM_SLOT, S_COM_WR,
		S_RQ_MEM, S_RQ_SLOT, S_RQ_EVAL,
		S_LEFT_MEM, S_LEFT_SLOT, S_LEFT_EVAL
	} state_t;

	state_t state_q;

	// latched command
	logic [OP_W-1:0]    op_q;
	logic [QUEUE_W-1:0] queue_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [EXT_W-1:0]   ext_q;
	logic [TOKEN_W-1:0] tok_q;
	logic [TOKEN_W-1:0] fid_q;
	logic               last_q;

	// counters and gathering state
	logic [CW-1:0]      slot_cnt_q;
	logic [FCW-1:0]     fence_cnt_q;
	logic [CW-1:0]      pend_cnt_q;
	logic [QUEUE_W-1:0] pend_queue_q;
	logic               pend_over_q;

	// walk state
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      n_q;
	logic [QUEUE_W-1:0] sq_q;
	logic [FW-1:0]      row_q;
	logic [SW-1:0]      sidx_q;
	logic [ADDR_W-1:0]  hit_addr_q;
	logic [EXT_W-1:0]   hit_ext_q;
	logic [MAX_SUB-1:0] seen_q;

	// fence headers
	logic [QUEUE_W-1:0] fq_q    [MAX_FENCE];
	logic [CW-1:0]      fsize_q [MAX_FENCE];
	logic               fdone_q [MAX_FENCE];

	result_t res_q;
	logic    res_valid_q;

	// memory ports
	logic               slot_we;
	logic [SW-1:0]      slot_waddr, slot_raddr;
	slot_t              slot_wdata, slot_rd;
	logic               mem_we;
	logic [FW+SW-1:0]   mem_waddr, mem_raddr;
	logic [TOKEN_W-1:0] mem_rd;

	// decode helpers
	logic               tok_ok, fid_ok, first, store, row_free, last_idx;
	logic [FW-1:0]      fidx;
	logic [SW-1:0]      tslot, mslot;
	logic [QUEUE_W-1:0] pq_n;
	logic [CW-1:0]      cnt_n;
	logic               over_n, mtok_ok;

	function automatic result_t mk_res(status_t st, logic [TOKEN_O_W-1:0] tk,
			logic [ADDR_W-1:0] a, logic [EXT_W-1:0] e, logic f);
		result_t r;
		r.status = st;
		r.token  = tk;
		r.addr   = a;
		r.ext    = e;
		r.flag   = f;
		return r;
	endfunction

	assign s_tready = (state_q == S_IDLE) && !res_valid_q;
	assign m_tvalid = res_valid_q;
	assign m_tdata  = {4'b0, res_q.flag, res_q.ext, res_q.addr, res_q.token, res_q.status};

	always_comb begin
		tok_ok   = (tok_q != '0) && ({1'b0, tok_q} <= 9'(slot_cnt_q));
		fid_ok   = (fid_q != '0) && ({1'b0, fid_q} <= 9'(fence_cnt_q));
		fidx     = FW'(fid_q - 8'd1);
		tslot    = SW'(tok_q - 8'd1);
		mslot    = SW'(mem_rd - 8'd1);
		mtok_ok  = (mem_rd != '0) && ({1'b0, mem_rd} <= 9'(slot_cnt_q));
		first    = (pend_cnt_q == '0) && !pend_over_q;
		pq_n     = first ? queue_q : pend_queue_q;
		store    = pend_cnt_q != CW'(MAX_SUB);
		cnt_n    = store ? pend_cnt_q + CW'(1) : pend_cnt_q;
		over_n   = pend_over_q | ~store;
		row_free = fence_cnt_q != FCW'(MAX_FENCE);
		last_idx = (idx_q + CW'(1)) == n_q;
	end

	// memory port steering
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = sidx_q;
		slot_wdata = slot_rd;
		slot_raddr = mslot;
		mem_we     = 1'b0;
		mem_waddr  = {fence_cnt_q[FW-1:0], pend_cnt_q[SW-1:0]};
		mem_raddr  = {row_q, idx_q[SW-1:0]};
		unique case (state_q)
			S_EXEC: begin
				slot_raddr = tslot;
				if (op_q == OP_SUBMIT && queue_q != '0 && slot_cnt_q != CW'(MAX_SUB)) begin
					slot_we    = 1'b1;
					slot_waddr = slot_cnt_q[SW-1:0];
					slot_wdata = '{phase: PH_SUBMITTED, queue: queue_q, addr: addr_q,
						ext: ext_q};
				end
				mem_we = (op_q == OP_SYNC) && store && row_free;
			end
			S_CPL: begin
				slot_we = (slot_rd.queue == queue_q) && (slot_rd.phase == PH_SUBMITTED);
				slot_wdata.phase = PH_COMPLETED;
			end
			S_COM_WR: begin
				slot_we = 1'b1;
				slot_wdata.phase = PH_SYNCED;
			end
			S_RQ_EVAL: begin
				slot_we = (slot_rd.phase == PH_SYNCED) && (slot_rd.addr == addr_q) &&
					(slot_rd.ext == ext_q);
				slot_wdata.phase = PH_REACQUIRED;
			end
			default: begin
			end
		endcase
	end

	sft_ram #(.DW(SLOT_W), .AW(SW)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rd)
	);

	// member rows; row fence_count doubles as the gathering buffer
	sft_ram #(.DW(TOKEN_W), .AW(FW + SW)) u_member_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (tok_q),
		.raddr (mem_raddr),
		.rdata (mem_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slot_cnt_q   <= '0;
			fence_cnt_q  <= '0;
			pend_cnt_q   <= '0;
			pend_queue_q <= '0;
			pend_over_q  <= 1'b0;
			res_valid_q  <= 1'b0;
			seen_q       <= '0;
		end else begin
			if (res_valid_q && m_tready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						op_q    <= s_tdata[2:0];
						queue_q <= s_tdata[18:3];
						addr_q  <= s_tdata[82:19];
						ext_q   <= s_tdata[114:83];
						tok_q   <= s_tdata[122:115];
						fid_q   <= s_tdata[130:123];
						last_q  <= s_tlast;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q     <= S_IDLE;
					res_valid_q <= 1'b1;
					res_q       <= mk_res(ST_BAD_ARG, '0, '0, '0, 1'b0);
					idx_q       <= '0;
					case (op_q)
						OP_SUBMIT: begin
							if (queue_q == '0) begin
								res_q <= mk_res(ST_BAD_ARG, '0, '0, '0, 1'b0);
							end else if (slot_cnt_q == CW'(MAX_SUB)) begin
								res_q <= mk_res(ST_FULL, '0, '0, '0, 1'b0);
							end else begin
								slot_cnt_q <= slot_cnt_q + CW'(1);
								res_q <= mk_res(ST_OK, TOKEN_O_W'(slot_cnt_q + CW'(1)),
									addr_q, ext_q, 1'b0);
							end
						end
						OP_COMPLETE: begin
							if (!tok_ok) begin
								res_q <= mk_res(ST_UNKNOWN_SUB, '0, '0, '0, 1'b0);
							end else begin
								res_valid_q <= 1'b0;
								sidx_q      <= tslot;
								state_q     <= S_CPL;
							end
						end
						OP_SYNC: begin
							if (!last_q) begin
								res_valid_q  <= 1'b0;
								pend_queue_q <= pq_n;
								pend_cnt_q   <= cnt_n;
								pend_over_q  <= over_n;
							end else begin
								pend_queue_q <= '0;
								pend_cnt_q   <= '0;
								pend_over_q  <= 1'b0;
								if (pq_n == '0 || over_n || cnt_n == '0) begin
									res_q <= mk_res(ST_BAD_ARG, '0, '0, '0, 1'b0);
								end else if (!row_free) begin
									res_q <= mk_res(ST_FULL, '0, '0, '0, 1'b0);
								end else begin
									res_valid_q <= 1'b0;
									sq_q        <= pq_n;
									n_q         <= cnt_n;
									row_q       <= fence_cnt_q[FW-1:0];
									seen_q      <= '0;
									state_q     <= S_CHK_MEM;
								end
							end
						end
						OP_REACQ: begin
							if (queue_q == '0) begin
								res_q <= mk_res(ST_BAD_ARG, '0, '0, '0, 1'b0);
							end else if (!fid_ok) begin
								res_q <= mk_res(ST_UNKNOWN_FENCE, '0, '0, '0, 1'b0);
							end else if (fq_q[fidx] != queue_q) begin
								res_q <= mk_res(ST_QUEUE_MISMATCH, '0, '0, '0, 1'b0);
							end else if (fdone_q[fidx]) begin
								res_q <= mk_res(ST_BAD_STATE, '0, '0, '0, 1'b0);
							end else begin
								res_valid_q <= 1'b0;
								row_q       <= fidx;
								n_q         <= fsize_q[fidx];
								state_q     <= S_RQ_MEM;
							end
						end
						OP_QUERY: begin
							if (!fid_ok) begin
								res_q <= mk_res(ST_UNKNOWN_FENCE, '0, '0, '0, 1'b0);
							end else begin
								res_q <= mk_res(ST_OK, '0, '0, '0, fdone_q[fidx]);
							end
						end
						default: begin
							res_q <= mk_res(ST_BAD_ARG, '0, '0, '0, 1'b0);
						end
					endcase
				end
				S_CPL: begin
					state_q     <= S_IDLE;
					res_valid_q <= 1'b1;
					if (slot_rd.queue != queue_q) begin
						res_q <= mk_res(ST_QUEUE_MISMATCH, '0, '0, '0, 1'b0);
					end else if (slot_rd.phase != PH_SUBMITTED) begin
						res_q <= mk_res(ST_BAD_STATE, '0, '0, '0, 1'b0);
					end else begin
						res_q <= mk_res(ST_OK, TOKEN_O_W'(tok_q), '0, '0, 1'b0);
					end
				end
				S_CHK_MEM: state_q <= S_CHK_SLOT;
				S_CHK_SLOT: begin
					if (!mtok_ok) begin
						res_valid_q <= 1'b1;
						res_q       <= mk_res(ST_UNKNOWN_SUB, '0, '0, '0, 1'b0);
						state_q     <= S_IDLE;
					end else begin
						sidx_q  <= mslot;
						state_q <= S_CHK_EVAL;
					end
				end
				S_CHK_EVAL: begin
					if (slot_rd.queue != sq_q) begin
						res_valid_q <= 1'b1;
						res_q       <= mk_res(ST_QUEUE_MISMATCH, '0, '0, '0, 1'b0);
						state_q     <= S_IDLE;
					end else if (slot_rd.phase != PH_COMPLETED) begin
						res_valid_q <= 1'b1;
						res_q       <= mk_res(ST_BAD_STATE, '0, '0, '0, 1'b0);
						state_q     <= S_IDLE;
					end else if (seen_q[sidx_q]) begin
						res_valid_q <= 1'b1;
						res_q       <= mk_res(ST_DUPLICATE, '0, '0, '0, 1'b0);
						state_q     <= S_IDLE;
					end else begin
						seen_q[sidx_q] <= 1'b1;
						idx_q          <= last_idx ? '0 : idx_q + CW'(1);
						state_q        <= last_idx ? S_COM_MEM : S_CHK_MEM;
					end
				end
				S_COM_MEM: state_q <= S_COM_SLOT;
				S_COM_SLOT: begin
					sidx_q  <= mslot;
					state_q <= S_COM_WR;
				end
				S_COM_WR: begin
					if (last_idx) begin
						fq_q[row_q]    <= sq_q;
						fsize_q[row_q] <= n_q;
						fdone_q[row_q] <= 1'b0;
						fence_cnt_q    <= fence_cnt_q + FCW'(1);
						res_valid_q    <= 1'b1;
						res_q <= mk_res(ST_OK, TOKEN_O_W'(fence_cnt_q + FCW'(1)), '0, '0, 1'b0);
						state_q        <= S_IDLE;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_COM_MEM;
					end
				end
				S_RQ_MEM: state_q <= S_RQ_SLOT;
				S_RQ_SLOT: begin
					sidx_q  <= mslot;
					state_q <= S_RQ_EVAL;
				end
				S_RQ_EVAL: begin
					if (slot_we) begin
						hit_addr_q <= slot_rd.addr;
						hit_ext_q  <= slot_rd.ext;
						idx_q      <= '0;
						state_q    <= S_LEFT_MEM;
					end else if (last_idx) begin
						res_valid_q <= 1'b1;
						res_q       <= mk_res(ST_NOT_IN_FENCE, '0, '0, '0, 1'b0);
						state_q     <= S_IDLE;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_RQ_MEM;
					end
				end
				S_LEFT_MEM: state_q <= S_LEFT_SLOT;
				S_LEFT_SLOT: state_q <= S_LEFT_EVAL;
				S_LEFT_EVAL: begin
					// stop at the first member still out; fence done only if none
					if (slot_rd.phase != PH_REACQUIRED || last_idx) begin
						if (slot_rd.phase == PH_REACQUIRED) begin
							fdone_q[row_q] <= 1'b1;
						end
						res_valid_q <= 1'b1;
						res_q       <= mk_res(ST_OK, '0, hit_addr_q, hit_ext_q, 1'b0);
						state_q     <= S_IDLE;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_LEFT_MEM;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_take_while_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("command taken while a result is pending");
	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(slot_cnt_q <= CW'(MAX_SUB)) && (pend_cnt_q <= CW'(MAX_SUB)))
		else $error("slot or pending count beyond capacity");
	a_fence_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(fence_cnt_q != $past(fence_cnt_q)) |->
		(fence_cnt_q == $past(fence_cnt_q) + FCW'(1)) && m_tvalid)
		else $error("fence count moved without a fence result");
`endif

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for submission_fence_tracker: a predictor of the slot,
// fence and sync-set tables computes each result a command gives, and each
// result transfer is checked field by field. Directed cases come first, then
// well-formed random command sequences mixed with noise, then table-full,
// oversize sync sets and back-pressure stretches.
// ----------------------------------------------------------------------------
module tb_top;
	import sft_pkg::*;

	localparam int NSLOT       = 64;
	localparam int NFENCE      = 32;
	localparam int SLOT_BUDGET = 48;   // slots the random part may use
	localparam int FENCE_BUDGET = 24;  // fences the random part may create
	localparam int STALL_LIMIT = 6000; // cycles without any transfer

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [135:0] s_tdata = '0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [111:0] m_tdata;

	submission_fence_tracker dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// tracker state as predicted
	logic [QUEUE_W-1:0] sl_q    [NSLOT];
	logic [ADDR_W-1:0]  sl_addr [NSLOT];
	logic [EXT_W-1:0]   sl_ext  [NSLOT];
	logic [PHASE_W-1:0] sl_ph   [NSLOT];
	int                 n_slots;
	logic [QUEUE_W-1:0] fn_q    [NFENCE];
	int                 fn_size [NFENCE];
	bit                 fn_done [NFENCE];
	int                 fn_mem  [NFENCE][NSLOT];
	int                 n_fences;
	logic [7:0]         pend_tok [NSLOT];
	int                 pend_n;
	logic [QUEUE_W-1:0] pend_q;
	bit                 pend_over;

	result_t     expected_results[$];
	int          n_sent = 0, n_results = 0, n_errors = 0;
	bit          tx_idle_on = 1'b1, rx_idle_on = 1'b1;
	bit          hold_now = 1'b0;
	int          hold_left = 0, rx_gap = 0, quiet_cycles = 0;

	function automatic int slot_index(logic [7:0] tok);
		if (tok == 0 || tok > n_slots) return -1;
		return tok - 1;
	endfunction

	// Applies one command to the predicted state; has = 0 for a sync element
	// that is not the last of its set.
	task automatic track_command(input logic [2:0] op, input logic [15:0] q,
			input logic [63:0] addr, input logic [31:0] ext, input logic [7:0] tok,
			input logic [7:0] fid, input bit last, output bit has, output result_t r);
		int s, f, i, j, hit, n;
		bit left, over;
		logic [15:0] sq;
		status_t st;
		r = '0;
		r.status = ST_OK;
		has = 1'b1;
		case (op)
			OP_SUBMIT: begin
				if (q == 0) r.status = ST_BAD_ARG;
				else if (n_slots >= NSLOT) r.status = ST_FULL;
				else begin
					sl_q[n_slots] = q;
					sl_addr[n_slots] = addr;
					sl_ext[n_slots] = ext;
					sl_ph[n_slots] = PH_SUBMITTED;
					n_slots++;
					r.token = 7'(n_slots);
					r.addr = addr;
					r.ext = ext;
				end
			end
			OP_COMPLETE: begin
				s = slot_index(tok);
				if (s < 0) r.status = ST_UNKNOWN_SUB;
				else if (sl_q[s] != q) r.status = ST_QUEUE_MISMATCH;
				else if (sl_ph[s] != PH_SUBMITTED) r.status = ST_BAD_STATE;
				else begin
					sl_ph[s] = PH_COMPLETED;
					r.token = 7'(tok);
				end
			end
			OP_SYNC: begin
				// queue is latched from the first element of a set
				if (pend_n == 0 && !pend_over) pend_q = q;
				if (pend_n < NSLOT) begin
					pend_tok[pend_n] = tok;
					pend_n++;
				end else pend_over = 1'b1;
				if (!last) has = 1'b0;
				else begin
					sq = pend_q;
					over = pend_over;
					n = pend_n;
					pend_n = 0;
					pend_over = 1'b0;
					pend_q = '0;
					if (sq == 0 || over || n == 0) r.status = ST_BAD_ARG;
					else if (n_fences >= NFENCE) r.status = ST_FULL;
					else begin
						st = ST_OK;
						for (i = 0; i < n && st == ST_OK; i++) begin
							s = slot_index(pend_tok[i]);
							if (s < 0) st = ST_UNKNOWN_SUB;
							else if (sl_q[s] != sq) st = ST_QUEUE_MISMATCH;
							else if (sl_ph[s] != PH_COMPLETED) st = ST_BAD_STATE;
							else
								for (j = 0; j < i; j++)
									if (pend_tok[j] == pend_tok[i]) st = ST_DUPLICATE;
						end
						r.status = st;
						if (st == ST_OK) begin
							fn_q[n_fences] = sq;
							fn_size[n_fences] = n;
							fn_done[n_fences] = 1'b0;
							for (i = 0; i < n; i++) begin
								fn_mem[n_fences][i] = pend_tok[i] - 1;
								sl_ph[pend_tok[i] - 1] = PH_SYNCED;
							end
							n_fences++;
							r.token = 7'(n_fences);
						end
					end
				end
			end
			OP_REACQ: begin
				if (q == 0) r.status = ST_BAD_ARG;
				else if (fid == 0 || fid > n_fences) r.status = ST_UNKNOWN_FENCE;
				else begin
					f = fid - 1;
					hit = -1;
					if (fn_q[f] != q) r.status = ST_QUEUE_MISMATCH;
					else if (fn_done[f]) r.status = ST_BAD_STATE;
					else begin
						for (i = 0; i < fn_size[f] && hit < 0; i++) begin
							s = fn_mem[f][i];
							if (sl_ph[s] == PH_SYNCED && sl_addr[s] == addr && sl_ext[s] == ext)
								hit = s;
						end
						if (hit < 0) r.status = ST_NOT_IN_FENCE;
						else begin
							sl_ph[hit] = PH_REACQUIRED;
							left = 1'b0;
							for (i = 0; i < fn_size[f]; i++)
								if (sl_ph[fn_mem[f][i]] != PH_REACQUIRED) left = 1'b1;
							if (!left) fn_done[f] = 1'b1;
							r.addr = sl_addr[hit];
							r.ext = sl_ext[hit];
						end
					end
				end
			end
			OP_QUERY: begin
				if (fid == 0 || fid > n_fences) r.status = ST_UNKNOWN_FENCE;
				else r.flag = fn_done[fid - 1];
			end
			default: r.status = ST_BAD_ARG;
		endcase
	endtask

	// Offers one command, waits for its transfer and records the prediction.
	task automatic send_item(input logic [2:0] op, input logic [15:0] q,
			input logic [63:0] addr, input logic [31:0] ext, input logic [7:0] tok,
			input logic [7:0] fid, input bit last);
		bit has;
		result_t r;
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, fid, tok, ext, addr, q, op};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		track_command(op, q, addr, ext, tok, fid, last, has, r);
		if (has) expected_results.push_back(r);
		n_sent++;
	endtask

	task automatic drain_results();
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [15:0] pick_queue();
		case ($urandom_range(0, 3))
			0: return 16'd1;
			1: return 16'd2;
			2: return 16'hFFFF;
			default: return 16'($urandom_range(1, 65535));
		endcase
	endfunction

	// receiver: random stall bursts, plus one long hold on request
	always @(posedge clk) begin
		if (hold_now) begin
			hold_now = 1'b0;
			hold_left = 250;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			m_tready <= 1'b0;
		end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
			rx_gap = $urandom_range(1, 18) - 1;
			m_tready <= 1'b0;
		end else
			m_tready <= 1'b1;
	end

	// result checker and watchdog
	always @(posedge clk) begin
		result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (expected_results.size() == 0) begin
				n_errors++;
				if (n_errors <= 10) $display("ERROR: unexpected result %h", m_tdata);
			end else begin
				e = expected_results.pop_front();
				if (m_tdata[3:0] !== e.status || m_tdata[10:4] !== e.token ||
						m_tdata[74:11] !== e.addr || m_tdata[106:75] !== e.ext ||
						m_tdata[107] !== e.flag) begin
					n_errors++;
					if (n_errors <= 10)
						$display("ERROR: result %0d exp st=%0d tok=%0d a=%h e=%h f=%b, got st=%0d tok=%0d a=%h e=%h f=%b",
							n_results, e.status, e.token, e.addr, e.ext, e.flag,
							m_tdata[3:0], m_tdata[10:4], m_tdata[74:11], m_tdata[106:75],
							m_tdata[107]);
				end
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
			$display("FAIL submission_fence_tracker");
			$finish;
		end
	end

	// every opcode, each status code but ST_FULL, and the sync/reacquire corner cases
	task automatic test_directed();
		send_item(OP_SUBMIT, 16'd0, 64'd5, 32'd5, 8'd0, 8'd0, 1'b0);        // zero queue
		send_item(OP_SUBMIT, 16'hFFFF, '1, '1, 8'hFF, 8'hFF, 1'b1);          // slot 1
		send_item(OP_SUBMIT, 16'd1, 64'd0, 32'd0, 8'd0, 8'd0, 1'b0);         // slot 2
		send_item(OP_SUBMIT, 16'd1, rand64(), $urandom, 8'd0, 8'd0, 1'b0);   // slot 3
		send_item(OP_COMPLETE, 16'd1, '0, '0, 8'd0, 8'd0, 1'b0);             // unknown
		send_item(OP_COMPLETE, 16'd1, '0, '0, 8'hFF, 8'd0, 1'b0);            // unknown
		send_item(OP_COMPLETE, 16'd2, '0, '0, 8'd2, 8'd0, 1'b0);             // wrong queue
		send_item(OP_COMPLETE, 16'd1, '0, '0, 8'd2, 8'd0, 1'b0);
		send_item(OP_COMPLETE, 16'd1, '0, '0, 8'd2, 8'd0, 1'b0);             // not submitted
		send_item(OP_COMPLETE, 16'd1, '0, '0, 8'd3, 8'd0, 1'b0);
		send_item(OP_COMPLETE, 16'hFFFF, '0, '0, 8'd1, 8'd0, 1'b0);
		send_item(OP_SYNC, 16'd1, '0, '0, 8'd9, 8'd0, 1'b1);                 // unknown token
		send_item(OP_SYNC, 16'd0, '0, '0, 8'd2, 8'd0, 1'b1);                 // zero queue
		send_item(OP_SYNC, 16'd2, '0, '0, 8'd2, 8'd0, 1'b1);                 // queue mismatch
		send_item(OP_SYNC, 16'hFFFF, '0, '0, 8'd1, 8'd0, 1'b0);
		send_item(OP_SYNC, 16'd7, '0, '0, 8'd1, 8'd0, 1'b1);                 // duplicate
		// later elements' queue is ignored
		send_item(OP_SYNC, 16'd1, '0, '0, 8'd2, 8'd0, 1'b0);
		send_item(OP_SYNC, 16'd0, '0, '0, 8'd3, 8'd0, 1'b1);                 // fence 1
		send_item(OP_SYNC, 16'd1, '0, '0, 8'd2, 8'd0, 1'b1);                 // already synced
		for (int op = 5; op < 8; op++)
			send_item(3'(op), 16'd1, '0, '0, 8'd1, 8'd1, 1'b0);
		send_item(OP_QUERY, 16'd0, '0, '0, 8'd0, 8'd0, 1'b0);
		send_item(OP_REACQ, 16'd0, '0, '0, 8'd0, 8'd1, 1'b0);
		send_item(OP_REACQ, 16'd1, '0, '0, 8'd0, 8'd200, 1'b0);
		send_item(OP_REACQ, 16'd2, '0, '0, 8'd0, 8'd1, 1'b0);
		send_item(OP_REACQ, 16'd1, 64'd1, '0, 8'd0, 8'd1, 1'b0);            // no match
		send_item(OP_REACQ, 16'd1, 64'd0, 32'd0, 8'd0, 8'd1, 1'b0);
		send_item(OP_QUERY, 16'd0, '0, '0, 8'd0, 8'd1, 1'b0);
		send_item(OP_REACQ, 16'd1, sl_addr[2], sl_ext[2], 8'd0, 8'd1, 1'b0); // consumes
		send_item(OP_REACQ, 16'd1, sl_addr[2], sl_ext[2], 8'd0, 8'd1, 1'b0); // consumed
		send_item(OP_QUERY, 16'd0, '0, '0, 8'd0, 8'd1, 1'b0);
	endtask

	// one sync set over completed slots of one queue, sometimes broken
	task automatic send_sync_set();
		int cand[$], same[$], toks[$], sub_only[$];
		int base, k, kind, idx;
		logic [15:0] q;
		for (int i = 0; i < n_slots; i++) begin
			if (sl_ph[i] == PH_COMPLETED) cand.push_back(i);
			if (sl_ph[i] == PH_SUBMITTED) sub_only.push_back(i);
		end
		if (cand.size() == 0) begin
			send_item(OP_SYNC, pick_queue(), rand64(), $urandom, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 1'b1);
			return;
		end
		base = cand[$urandom_range(0, cand.size() - 1)];
		q = sl_q[base];
		foreach (cand[i]) if (sl_q[cand[i]] == q) same.push_back(cand[i]);
		same.shuffle();
		k = $urandom_range(1, same.size() < 4 ? same.size() : 4);
		for (int i = 0; i < k; i++) toks.push_back(same[i] + 1);
		if (n_fences >= FENCE_BUDGET || $urandom_range(0, 4) == 0) begin
			kind = $urandom_range(0, 3);
			idx = $urandom_range(0, toks.size());
			case (kind)
				0: toks.insert(idx, toks[0]);
				1: toks.insert(idx, $urandom_range(0, 255));
				2: q = q ^ 16'h0001;
				default: toks.insert(idx, sub_only.size() != 0 ?
					sub_only[$urandom_range(0, sub_only.size() - 1)] + 1 : 0);
			endcase
		end
		foreach (toks[i])
			send_item(OP_SYNC, i == 0 ? q : 16'($urandom), rand64(), $urandom, 8'(toks[i]),
				8'($urandom_range(0, 255)), i == toks.size() - 1);
	endtask

	task automatic send_reacquire();
		int f, s;
		int live[$];
		if (n_fences == 0 || $urandom_range(0, 5) == 0) begin
			send_item(OP_REACQ, 16'($urandom_range(0, 3)), rand64(), $urandom,
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 40)),
				1'($urandom_range(0, 1)));
			return;
		end
		f = $urandom_range(0, n_fences - 1);
		for (int i = 0; i < fn_size[f]; i++)
			if (sl_ph[fn_mem[f][i]] == PH_SYNCED) live.push_back(fn_mem[f][i]);
		s = live.size() != 0 ? live[$urandom_range(0, live.size() - 1)] : fn_mem[f][0];
		send_item(OP_REACQ, fn_q[f], sl_addr[s], sl_ext[s], 8'($urandom_range(0, 255)),
			8'(f + 1), 1'b0);
	endtask

	task automatic test_random_mix();
		int r, s;
		int subs[$];
		while (n_sent < 1150) begin
			if (n_sent > 1040) tx_idle_on = 1'b0;
			if (n_sent > 1040) rx_idle_on = 1'b0;
			r = $urandom_range(0, 99);
			subs.delete();
			for (int i = 0; i < n_slots; i++) if (sl_ph[i] == PH_SUBMITTED) subs.push_back(i);
			if (r < 6 || (r < 35 && subs.size() == 0 && n_slots < SLOT_BUDGET)) begin
				if (n_slots < SLOT_BUDGET)
					send_item(OP_SUBMIT, pick_queue(), rand64(), $urandom,
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
				else
					send_item(OP_SUBMIT, 16'd0, rand64(), $urandom, 8'd0, 8'd0, 1'b0);
			end else if (r < 35 && subs.size() != 0) begin
				s = subs[$urandom_range(0, subs.size() - 1)];
				send_item(OP_COMPLETE, $urandom_range(0, 9) == 0 ? sl_q[s] + 16'd1 : sl_q[s],
					rand64(), $urandom, 8'(s + 1), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end else if (r < 55)
				send_sync_set();
			else if (r < 75)
				send_reacquire();
			else if (r < 85)
				send_item(OP_QUERY, 16'($urandom), rand64(), $urandom,
					8'($urandom_range(0, 255)), 8'($urandom_range(0, n_fences + 3)),
					1'($urandom_range(0, 1)));
			else begin
				r = $urandom_range(0, 7);
				send_item(3'(r), (r == OP_SUBMIT && n_slots >= SLOT_BUDGET) ? 16'd0 :
					16'($urandom), rand64(), $urandom, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)),
					r == OP_SYNC ? $urandom_range(0, 9) < 7 : 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// fills both tables, hits full on submit and on sync, then reacquires the last fence
	task automatic test_tables_full();
		int s;
		while (n_slots < NSLOT)
			send_item(OP_SUBMIT, 16'd7, rand64(), $urandom, 8'd0, 8'd0, 1'b0);
		for (int i = 0; i < NSLOT; i++)
			if (sl_ph[i] == PH_SUBMITTED)
				send_item(OP_COMPLETE, sl_q[i], '0, '0, 8'(i + 1), 8'd0, 1'b0);
		for (int i = 0; i < NSLOT && n_fences < NFENCE; i++)
			if (sl_ph[i] == PH_COMPLETED)
				send_item(OP_SYNC, sl_q[i], '0, '0, 8'(i + 1), 8'd0, 1'b1);
		send_item(OP_SUBMIT, 16'd7, rand64(), $urandom, 8'd0, 8'd0, 1'b0);
		send_item(OP_SYNC, 16'd7, '0, '0, 8'd64, 8'd0, 1'b1);
		for (int i = 0; i < fn_size[NFENCE - 1]; i++) begin
			s = fn_mem[NFENCE - 1][i];
			send_item(OP_REACQ, fn_q[NFENCE - 1], sl_addr[s], sl_ext[s], 8'd0, 8'(NFENCE),
				1'b0);
		end
		send_item(OP_QUERY, 16'd0, '0, '0, 8'd0, 8'(NFENCE), 1'b0);
	endtask

	// a set one token longer than the table, then one exactly as long
	task automatic test_sync_overflow();
		for (int i = 0; i <= NSLOT; i++)
			send_item(OP_SYNC, 16'd1, '0, '0, 8'($urandom_range(1, 64)), 8'd0, i == NSLOT);
		for (int i = 0; i < NSLOT; i++)
			send_item(OP_SYNC, 16'd1, '0, '0, 8'($urandom_range(1, 64)), 8'd0,
				i == NSLOT - 1);
	endtask

	// long receiver hold while commands keep coming, then a full sender pause
	task automatic test_backpressure();
		hold_now = 1'b1;
		for (int i = 0; i < 8; i++)
			send_item(OP_QUERY, 16'd0, '0, '0, 8'd0, 8'($urandom_range(0, 40)), 1'b0);
		s_tvalid <= 1'b0;
		drain_results();
		for (int i = 0; i < 4; i++)
			send_item(OP_QUERY, 16'd0, '0, '0, 8'd0, 8'($urandom_range(0, 40)), 1'b0);
	endtask

	initial begin
		n_slots = 0;
		n_fences = 0;
		pend_n = 0;
		pend_q = '0;
		pend_over = 1'b0;
		foreach (sl_ph[i]) begin
			sl_q[i] = '0; sl_addr[i] = '0; sl_ext[i] = '0; sl_ph[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix();
		test_tables_full();
		test_sync_overflow();
		test_backpressure();
		s_tvalid <= 1'b0;
		drain_results();
		repeat (400) @(posedge clk);
		$display("Covered %0d commands and %0d results; %0d of %0d slots and %0d of %0d fences used.",
			n_sent, n_results, n_slots, NSLOT, n_fences, NFENCE);
		$display("Mismatches: %0d", n_errors);
		if (n_errors == 0 && expected_results.size() == 0)
			$display("PASS submission_fence_tracker");
		else
			$display("FAIL submission_fence_tracker");
		$finish;
	end

endmodule
